[rtl/core/fsc_pkg.sv]
// fsc_pkg: shared types and codes for the flash sector cache policy engine.
// No dependencies; imported by flash_sector_cache_policy.
`default_nettype none

package fsc_pkg;

    // Operation codes carried on the opcode input
    localparam logic [2:0] OP_READ        = 3'd0;
    localparam logic [2:0] OP_FILL        = 3'd1;
    localparam logic [2:0] OP_WRITE       = 3'd2;
    localparam logic [2:0] OP_FLUSH_ALL   = 3'd3;
    localparam logic [2:0] OP_FLUSH_RANGE = 3'd4;
    localparam logic [2:0] OP_CLOSE_RANGE = 3'd5;

    // Result kinds
    localparam logic KIND_WB     = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Result status codes
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_MISS = 1'b1;

    // Entry modes
    typedef enum logic [1:0] {
        MODE_FREE   = 2'd0,
        MODE_FILLED = 2'd2,
        MODE_OFTEN  = 2'd3
    } mode_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_ALLOC,
        ST_EVSCAN,
        ST_EVTAKE,
        ST_RANGE,
        ST_FINAL
    } state_t;

endpackage

`default_nettype wire

[rtl/core/flash_sector_cache_policy.sv]
// flash_sector_cache_policy: tag and policy engine of a flash sector cache.
// Depends on fsc_pkg (opcodes, entry modes, sequencer states).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per transaction:
//   opcode, sector and range_end. Output channel (out_valid/out_ready) carries
//   result transactions: zero or more write-back requests (kind 0) followed by
//   exactly one final status (kind 1, last 1).
//   A single sequencer walks the slot table one slot per cycle through one
//   shared scan datapath, except while it waits on a stalled receiver;
//   in_ready is high only while it is idle. A read scans every slot; a
//   write stops at its first hit. A fill, or a write that misses, searches
//   for a free slot; an eviction takes one scan per evicted entry plus two
//   empty scans. Range operations scan every slot once before the status.
//   The output register holds a result until taken; when the receiver stalls
//   the sequencer waits at the next result it must emit. A new operation may
//   be accepted while the previous final status is still waiting.
//   Reset frees every slot, clears use counts, dirty marks and the search
//   pointer; stored sectors are not cleared and are only read for used slots.
`default_nettype none

module flash_sector_cache_policy #(
    parameter int SLOTS       = 16,
    parameter int SECTOR_BITS = 32,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [2:0]               opcode,
    input  wire logic [SECTOR_BITS-1:0]   sector,
    input  wire logic [SECTOR_BITS-1:0]   range_end,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          kind,
    output logic                          status,
    output logic [$clog2(SLOTS)-1:0]      slot,
    output logic [SECTOR_BITS-1:0]        out_sector,
    output logic                          last
);
    import fsc_pkg::*;

    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int KEY_W     = (SECTOR_BITS > COUNT_BITS) ? SECTOR_BITS : COUNT_BITS;
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS - 1);

    // Slot table
    mode_t                  mode_reg  [SLOTS];
    mode_t                  mode_next [SLOTS];
    logic [COUNT_BITS-1:0]  uses_reg  [SLOTS];
    logic [COUNT_BITS-1:0]  uses_next [SLOTS];
    logic                   dirty_reg [SLOTS];
    logic                   dirty_next[SLOTS];
    logic [SECTOR_BITS-1:0] sec_mem   [SLOTS];
    logic                   sec_we;
    logic [SLOT_BITS-1:0]   sec_waddr;
    logic [SECTOR_BITS-1:0] sec_rd_reg;

    // Sequencer and operand registers
    state_t                 state_reg, state_next;
    logic [2:0]             op_reg, op_next;
    logic [SECTOR_BITS-1:0] lo_reg, lo_next;
    logic [SECTOR_BITS-1:0] hi_reg, hi_next;
    logic [SLOT_BITS-1:0]   sp_reg, sp_next;
    logic [SLOT_BITS-1:0]   idx_reg, idx_next;
    logic [SLOT_BITS-1:0]   cnt_reg, cnt_next;
    logic                   evm_reg, evm_next;
    logic                   bf_reg, bf_next;
    logic [SLOT_BITS-1:0]   bslot_reg, bslot_next;
    logic [KEY_W-1:0]       bkey_reg, bkey_next;
    logic [SECTOR_BITS-1:0] bsec_reg, bsec_next;
    logic                   bdirty_reg, bdirty_next;
    logic                   hf_reg, hf_next;
    logic [SLOT_BITS-1:0]   hslot_reg, hslot_next;
    logic                   fstat_reg, fstat_next;
    logic [SLOT_BITS-1:0]   fslot_reg, fslot_next;
    logic [SECTOR_BITS-1:0] fsec_reg, fsec_next;

    // Output register
    logic                   ov_reg;
    logic                   okind_reg, ostat_reg, olast_reg;
    logic [SLOT_BITS-1:0]   oslot_reg;
    logic [SECTOR_BITS-1:0] osec_reg;
    logic                   emit_load, emit_kind, emit_stat, emit_last;
    logic [SLOT_BITS-1:0]   emit_slot;
    logic [SECTOR_BITS-1:0] emit_sec;

    // Shared scan datapath
    mode_t                  cur_mode;
    logic [SECTOR_BITS-1:0] cur_sec;
    logic [COUNT_BITS-1:0]  cur_uses;
    logic                   cur_dirty;
    logic                   match, in_rng, scan_last, can_emit, ev_cand;
    logic [KEY_W-1:0]       ev_key;
    logic [SLOT_BITS-1:0]   idx_inc, idx_dec;

    assign cur_mode  = mode_reg[idx_reg];
    assign cur_sec   = sec_rd_reg;
    assign cur_uses  = uses_reg[idx_reg];
    assign cur_dirty = dirty_reg[idx_reg];
    assign match     = (cur_mode != MODE_FREE) && (cur_sec == lo_reg);
    assign in_rng    = (cur_mode != MODE_FREE) && (cur_sec >= lo_reg) && (cur_sec < hi_reg);
    assign scan_last = (cnt_reg == LAST_SLOT);
    assign can_emit  = !ov_reg || out_ready;
    assign ev_cand   = (cur_mode == (evm_reg ? MODE_OFTEN : MODE_FILLED));
    assign ev_key    = evm_reg ? KEY_W'(cur_uses) : KEY_W'(cur_sec);
    assign idx_inc   = (idx_reg == LAST_SLOT) ? '0 : idx_reg + 1'b1;
    assign idx_dec   = (idx_reg == '0) ? LAST_SLOT : idx_reg - 1'b1;

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = ov_reg;
    assign kind       = okind_reg;
    assign status     = ostat_reg;
    assign slot       = oslot_reg;
    assign out_sector = osec_reg;
    assign last       = olast_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (opcode) inside
                        OP_READ, OP_WRITE:              state_next = ST_LOOKUP;
                        OP_FILL:                        state_next = ST_ALLOC;
                        OP_FLUSH_ALL:                   state_next = ST_EVSCAN;
                        OP_FLUSH_RANGE, OP_CLOSE_RANGE: state_next = ST_RANGE;
                        default:                        state_next = ST_FINAL;
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                if (op_reg == OP_WRITE && match)
                    state_next = ST_FINAL;
                else if (scan_last)
                    state_next = (op_reg == OP_READ) ? ST_FINAL : ST_ALLOC;
            end
            ST_ALLOC:
            begin
                if (cur_mode == MODE_FREE)
                    state_next = ST_FINAL;
                else if (scan_last)
                    state_next = ST_EVSCAN;
            end
            ST_EVSCAN:
            begin
                if (scan_last)
                    state_next = ST_EVTAKE;
            end
            ST_EVTAKE:
            begin
                if (bf_reg)
                begin
                    if (!bdirty_reg || can_emit)
                        state_next = ST_EVSCAN;
                end
                else
                    state_next = evm_reg ? ST_FINAL : ST_EVSCAN;
            end
            ST_RANGE:
            begin
                if (!(in_rng && op_reg == OP_FLUSH_RANGE && !can_emit) && scan_last)
                    state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                if (can_emit)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, table updates and result emission
    always_comb
    begin
        mode_next   = mode_reg;
        uses_next   = uses_reg;
        dirty_next  = dirty_reg;
        sec_we      = 1'b0;
        sec_waddr   = idx_reg;
        op_next     = op_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        sp_next     = sp_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        evm_next    = evm_reg;
        bf_next     = bf_reg;
        bslot_next  = bslot_reg;
        bkey_next   = bkey_reg;
        bsec_next   = bsec_reg;
        bdirty_next = bdirty_reg;
        hf_next     = hf_reg;
        hslot_next  = hslot_reg;
        fstat_next  = fstat_reg;
        fslot_next  = fslot_reg;
        fsec_next   = fsec_reg;
        emit_load   = 1'b0;
        emit_kind   = KIND_WB;
        emit_stat   = STAT_OK;
        emit_slot   = '0;
        emit_sec    = '0;
        emit_last   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    lo_next    = sector;
                    hi_next    = range_end;
                    idx_next   = (opcode == OP_READ || opcode == OP_WRITE || opcode == OP_FILL)
                                 ? sp_reg : '0;
                    cnt_next   = '0;
                    evm_next   = 1'b0;
                    bf_next    = 1'b0;
                    hf_next    = 1'b0;
                    fstat_next = STAT_OK;
                    fslot_next = '0;
                    fsec_next  = '0;
                end
            end
            ST_LOOKUP:
            begin
                // downward circular search from the search pointer
                if (match)
                begin
                    mode_next[idx_reg] = MODE_OFTEN;
                    if (op_reg == OP_READ)
                    begin
                        if (cur_uses != '1)
                            uses_next[idx_reg] = cur_uses + 1'b1;
                        hf_next    = 1'b1;
                        hslot_next = idx_reg;
                    end
                    else
                    begin
                        uses_next[idx_reg]  = cur_uses + 1'b1;
                        dirty_next[idx_reg] = 1'b1;
                        fstat_next = STAT_OK;
                        fslot_next = idx_reg;
                        fsec_next  = lo_reg;
                    end
                end
                idx_next = idx_dec;
                cnt_next = cnt_reg + 1'b1;
                if (op_reg == OP_READ && scan_last)
                begin
                    fstat_next = (hf_reg || match) ? STAT_OK : STAT_MISS;
                    fslot_next = match ? idx_reg : (hf_reg ? hslot_reg : '0);
                    fsec_next  = lo_reg;
                end
                if (op_reg == OP_WRITE && !match && scan_last)
                begin
                    idx_next = sp_reg;
                    cnt_next = '0;
                end
            end
            ST_ALLOC:
            begin
                // upward circular free-slot search
                if (cur_mode == MODE_FREE)
                begin
                    sec_we              = 1'b1;
                    sec_waddr           = idx_reg;
                    mode_next[idx_reg]  = MODE_FILLED;
                    uses_next[idx_reg]  = '0;
                    dirty_next[idx_reg] = (op_reg == OP_WRITE);
                    sp_next    = idx_reg;
                    fstat_next = (op_reg == OP_WRITE) ? STAT_MISS : STAT_OK;
                    fslot_next = idx_reg;
                    fsec_next  = lo_reg;
                end
                else
                begin
                    idx_next = idx_inc;
                    cnt_next = cnt_reg + 1'b1;
                    if (scan_last)
                    begin
                        idx_next = '0;
                        cnt_next = '0;
                        evm_next = 1'b0;
                        bf_next  = 1'b0;
                    end
                end
            end
            ST_EVSCAN:
            begin
                // minimum search over the current eviction class
                if (ev_cand && (!bf_reg || bkey_reg > ev_key))
                begin
                    bf_next     = 1'b1;
                    bslot_next  = idx_reg;
                    bkey_next   = ev_key;
                    bsec_next   = cur_sec;
                    bdirty_next = cur_dirty;
                end
                idx_next = idx_inc;
                cnt_next = cnt_reg + 1'b1;
                if (scan_last)
                begin
                    idx_next = '0;
                    cnt_next = '0;
                end
            end
            ST_EVTAKE:
            begin
                if (bf_reg)
                begin
                    if (!bdirty_reg || can_emit)
                    begin
                        if (bdirty_reg)
                        begin
                            emit_load = 1'b1;
                            emit_kind = KIND_WB;
                            emit_slot = bslot_reg;
                            emit_sec  = bsec_reg;
                        end
                        mode_next[bslot_reg]  = MODE_FREE;
                        uses_next[bslot_reg]  = '0;
                        dirty_next[bslot_reg] = 1'b0;
                        bf_next = 1'b0;
                    end
                end
                else if (!evm_reg)
                    evm_next = 1'b1;
                else if (op_reg == OP_FILL || op_reg == OP_WRITE)
                begin
                    // table now empty: the free search lands on the pointer itself
                    sec_we              = 1'b1;
                    sec_waddr           = sp_reg;
                    mode_next[sp_reg]   = MODE_FILLED;
                    uses_next[sp_reg]   = '0;
                    dirty_next[sp_reg]  = (op_reg == OP_WRITE);
                    fstat_next = (op_reg == OP_WRITE) ? STAT_MISS : STAT_OK;
                    fslot_next = sp_reg;
                    fsec_next  = lo_reg;
                end
            end
            ST_RANGE:
            begin
                if (!(in_rng && op_reg == OP_FLUSH_RANGE && !can_emit))
                begin
                    if (in_rng)
                    begin
                        if (op_reg == OP_FLUSH_RANGE)
                        begin
                            emit_load = 1'b1;
                            emit_kind = KIND_WB;
                            emit_slot = idx_reg;
                            emit_sec  = cur_sec;
                        end
                        mode_next[idx_reg]  = MODE_FREE;
                        uses_next[idx_reg]  = '0;
                        dirty_next[idx_reg] = 1'b0;
                    end
                    idx_next = idx_inc;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINAL:
            begin
                if (can_emit)
                begin
                    emit_load = 1'b1;
                    emit_kind = KIND_STATUS;
                    emit_stat = fstat_reg;
                    emit_slot = fslot_reg;
                    emit_sec  = fsec_reg;
                    emit_last = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control state and table flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sp_reg    <= '0;
            ov_reg    <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                mode_reg[i]  <= MODE_FREE;
                uses_reg[i]  <= '0;
                dirty_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            mode_reg  <= mode_next;
            uses_reg  <= uses_next;
            dirty_reg <= dirty_next;
            if (emit_load)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // Payload and scan registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        evm_reg    <= evm_next;
        bf_reg     <= bf_next;
        bslot_reg  <= bslot_next;
        bkey_reg   <= bkey_next;
        bsec_reg   <= bsec_next;
        bdirty_reg <= bdirty_next;
        hf_reg     <= hf_next;
        hslot_reg  <= hslot_next;
        fstat_reg  <= fstat_next;
        fslot_reg  <= fslot_next;
        fsec_reg   <= fsec_next;
        if (emit_load)
        begin
            okind_reg <= emit_kind;
            ostat_reg <= emit_stat;
            oslot_reg <= emit_slot;
            osec_reg  <= emit_sec;
            olast_reg <= emit_last;
        end
    end

    // Sector store; the read port follows the next scan index so the data
    // lines up with idx_reg
    always_ff @(posedge clk)
    begin
        if (sec_we)
            sec_mem[sec_waddr] <= lo_reg;
        sec_rd_reg <= sec_mem[idx_next];
    end

    // Checks
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit_load |-> can_emit)
        else $error("result loaded over a pending result");

    a_final_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINAL && state_next == ST_IDLE) |=> (ov_reg && olast_reg))
        else $error("final status not presented");

    a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (okind_reg == olast_reg))
        else $error("last flag and result kind disagree");

    a_alloc_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALLOC && state_next == ST_FINAL) |=> (mode_reg[sp_reg] == MODE_FILLED))
        else $error("allocated slot not marked filled");

endmodule

`default_nettype wire
